// File: rtl/core/ppvs_pkg.sv
// ----------------------------------------------------------------------------
// ppvs_pkg: shared types and helpers for the plot point viewport scaler
// Holds the controller/datapath handshake types, state and register codes,
// and the small arithmetic helpers of the scaling datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ppvs_pkg;

  // Default store depth
  localparam int MaxPointsDefault = 64;

  // Field widths
  localparam int CoordW = 16;
  localparam int PixW   = 14;
  localparam int MargW  = 11;
  localparam int ProdW  = CoordW + PixW;

  // Quotient never exceeds the span, which stays below 2**PixW
  localparam int DivSteps = PixW;
  localparam int StepW    = $clog2(DivSteps);

  // Register reset values
  localparam logic [PixW-1:0] ImageWidthReset  = PixW'(640);
  localparam logic [PixW-1:0] ImageHeightReset = PixW'(480);

  // Reciprocal of ten: floor(v * 52429 / 2**19) == v / 10 for any 14 bit v
  localparam logic [CoordW-1:0] Recip10 = 16'd52429;
  localparam int Recip10Shift = 19;

  // Configuration register indexes
  typedef enum logic {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // store one point, update maxima
    logic prep;      // latch margins, rewind read index
    logic rd;        // issue store read
    logic mul;       // form dividends, seed divider
    logic div_step;  // one restoring division step
    logic emit;      // register result, advance or close the set
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last_item;
    logic div_last;
  } status_t;

  typedef struct packed {
    logic [CoordW-1:0] rem;
    logic [PixW-1:0]   low;
  } div_t;

  // Margin: one tenth of an image size
  function automatic logic [MargW-1:0] div10(input logic [PixW-1:0] v);
    logic [ProdW-1:0] p;
    begin
      p = {{CoordW{1'b0}}, v} * {{PixW{1'b0}}, Recip10};
      div10 = p[Recip10Shift +: MargW];
    end
  endfunction

  // One restoring division step; the quotient bit shifts into low
  function automatic div_t div_step(input div_t cur, input logic [CoordW-1:0] dvs);
    logic [CoordW:0] t;
    div_t nxt;
    begin
      t = {cur.rem, cur.low[PixW-1]};
      if (t >= {1'b0, dvs}) begin
        nxt.rem = CoordW'(t - {1'b0, dvs});
        nxt.low = {cur.low[PixW-2:0], 1'b1};
      end else begin
        nxt.rem = t[CoordW-1:0];
        nxt.low = {cur.low[PixW-2:0], 1'b0};
      end
      div_step = nxt;
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ppvs_ram.sv
// ----------------------------------------------------------------------------
// ppvs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ppvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ppvs_ctrl.sv
// ----------------------------------------------------------------------------
// ppvs_ctrl: sequencer of the plot point viewport scaler
// Takes points while idle; after the last point walks the store, driving
// read, multiply, division and output steps of the datapath per point.
// ----------------------------------------------------------------------------
`default_nettype none

module ppvs_ctrl
  import ppvs_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  input  wire logic    last_point_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o,
  output logic         busy
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          if (last_point_i) begin
            state_d = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        cmd_o.emit = 1'b1;
        state_d    = status_i.last_item ? ST_IDLE : ST_READ;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Assertions
  a_busy_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) == !busy)
    else $error("busy does not track idle state");

  a_last_to_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_point_i) |=> (state_q == ST_PREP))
    else $error("last point did not start emission");

  a_out_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> ($past(state_q) == ST_DIV))
    else $error("output step not preceded by division");

endmodule

`default_nettype wire

// File: rtl/core/ppvs_dpath.sv
// ----------------------------------------------------------------------------
// ppvs_dpath: datapath of the plot point viewport scaler
// Point store, running maxima, configuration registers, margin logic, one
// multiplier per axis and a pair of restoring dividers, output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ppvs_dpath
  import ppvs_pkg::*;
#(
  parameter int MAX_POINTS = MaxPointsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  output status_t                status_o,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [PixW-1:0]   cfg_wdata_i,
  input  wire logic [CoordW-1:0] point_x_i,
  input  wire logic [CoordW-1:0] point_y_i,
  output logic                   result_valid_o,
  output logic      [PixW-1:0]   pixel_x_o,
  output logic      [PixW-1:0]   pixel_y_o,
  output logic                   last_out_o
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_POINTS);

  logic [PixW-1:0]   width_q, height_q;
  logic [CW-1:0]     count_q;
  logic [CoordW-1:0] max_x_q, max_y_q;
  logic [AW-1:0]     idx_q;
  logic [StepW-1:0]  step_q;
  logic [MargW-1:0]  mx_q, my_q;
  div_t              dx_q, dy_q, dx_d, dy_d;
  logic              valid_q, last_q;
  logic [PixW-1:0]   pix_x_q, pix_y_q;

  logic              store_ok;
  logic [2*CoordW-1:0] rdata;
  logic [PixW-1:0]   span_x, span_y;
  logic [ProdW-1:0]  prod_x, prod_y;
  logic [PixW-1:0]   quot_x, quot_y;
  logic [CoordW-1:0] max_y_m1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ImageWidthReset;
      height_q <= ImageHeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign store_ok = cmd_i.load && (count_q < MaxCount);

  // Point store
  ppvs_ram #(
    .WIDTH (2 * CoordW),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_ok),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({point_y_i, point_x_i}),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  // Set bookkeeping: fill count, maxima, read index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      max_x_q <= '0;
      max_y_q <= '0;
      idx_q   <= '0;
    end else begin
      if (store_ok) begin
        count_q <= count_q + CW'(1);
        if (point_x_i > max_x_q) max_x_q <= point_x_i;
        if (point_y_i > max_y_q) max_y_q <= point_y_i;
      end
      if (cmd_i.prep) begin
        idx_q <= '0;
      end
      if (cmd_i.emit) begin
        if (status_o.last_item) begin
          count_q <= '0;
          max_x_q <= '0;
          max_y_q <= '0;
          idx_q   <= '0;
        end else begin
          idx_q <= idx_q + AW'(1);
        end
      end
    end
  end

  // Margins, held for the whole pass
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      mx_q <= div10(width_q);
      my_q <= div10(height_q);
    end
  end

  assign span_x   = width_q  - {2'b0, mx_q, 1'b0};
  assign span_y   = height_q - {2'b0, my_q, 1'b0};
  assign max_y_m1 = max_y_q - CoordW'(1);

  // Dividends: floor for x, ceiling bias for y
  assign prod_x = {{PixW{1'b0}}, rdata[CoordW-1:0]} * {{CoordW{1'b0}}, span_x};
  assign prod_y = {{PixW{1'b0}}, rdata[2*CoordW-1:CoordW]} * {{CoordW{1'b0}}, span_y}
                + {{PixW{1'b0}}, max_y_m1};

  assign dx_d = div_step(dx_q, max_x_q);
  assign dy_d = div_step(dy_q, max_y_q);

  // Divider registers: seed from the product, then step
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      dx_q.rem <= prod_x[ProdW-1:PixW];
      dx_q.low <= prod_x[PixW-1:0];
      dy_q.rem <= prod_y[ProdW-1:PixW];
      dy_q.low <= prod_y[PixW-1:0];
    end else if (cmd_i.div_step) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.mul) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + StepW'(1);
    end
  end

  assign status_o.div_last  = (step_q == StepW'(DivSteps - 1));
  assign status_o.last_item = ((CW'(idx_q) + CW'(1)) == count_q);

  // Zero maximum: the point sits on the margin
  assign quot_x = (max_x_q == '0) ? '0 : dx_q.low;
  assign quot_y = (max_y_q == '0) ? '0 : dy_q.low;

  // Result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      pix_x_q <= quot_x + {3'b0, mx_q};
      pix_y_q <= height_q - {3'b0, my_q} - quot_y;
      last_q  <= status_o.last_item;
    end
  end

  assign result_valid_o = valid_q;
  assign pixel_x_o      = pix_x_q;
  assign pixel_y_o      = pix_y_q;
  assign last_out_o     = last_q;

  // Assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCount)
    else $error("fill count beyond store depth");

  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> !valid_q)
    else $error("back-to-back result strobes");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_step && (max_x_q != '0)) |-> (dx_q.rem < max_x_q))
    else $error("x divider remainder out of range");

  a_set_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && status_o.last_item) |=> (count_q == '0) && (max_x_q == '0))
    else $error("set not cleared after final result");

endmodule

`default_nettype wire

// File: rtl/core/plot_point_viewport_scaler_unit.sv
// ----------------------------------------------------------------------------
// plot_point_viewport_scaler_unit: plot point viewport scaler, top level
// Stores a set of points, tracks the maxima, then emits every point mapped
// into image pixels with a one-tenth margin on each axis.
// ----------------------------------------------------------------------------
// Points load one per cycle while busy is low: start with busy low moves one
// beat. A beat with last_point_i set closes the set; busy then rises and the
// block emits every stored point in arrival order. Emission begins with a setup
// step, then takes each stored point through a store read, a multiply, the
// bit-per-cycle restoring divider (x and y in parallel) and an output step;
// busy stays high until the output step of the final point. Each result is
// shown for a single cycle under result_valid_o and must be taken then: the
// receiver cannot stall the block. last_out_o marks the final result. Points
// beyond MAX_POINTS are dropped. Write the image size registers only while
// busy is low.
`default_nettype none

module plot_point_viewport_scaler_unit
  import ppvs_pkg::*;
#(
  parameter int MAX_POINTS = MaxPointsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [PixW-1:0]   cfg_wdata_i,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [CoordW-1:0] point_x_i,
  input  wire logic [CoordW-1:0] point_y_i,
  input  wire logic              last_point_i,
  output logic                   result_valid_o,
  output logic      [PixW-1:0]   pixel_x_o,
  output logic      [PixW-1:0]   pixel_y_o,
  output logic                   last_out_o
);

  cmd_t    cmd;
  status_t status;

  // Sequencer
  ppvs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .last_point_i (last_point_i),
    .status_i     (status),
    .cmd_o        (cmd),
    .busy         (busy)
  );

  // Datapath
  ppvs_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .result_valid_o (result_valid_o),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .last_out_o     (last_out_o)
  );

endmodule

`default_nettype wire
